### rtl/fenced_deferred_release_table_top_assert.svh
`ifndef FENCED_DEFERRED_RELEASE_TABLE_TOP_ASSERT_SVH
`define FENCED_DEFERRED_RELEASE_TABLE_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define FDRT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the next clock cycle.
`define FDRT_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

### rtl/fdrt_pkg.sv
package fdrt_pkg;

    localparam int CAPACITY    = 64;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int ID_W        = 32;
    localparam int HANDLE_W    = 32;
    localparam int FENCE_W     = 64;
    localparam int COUNT_OUT_W = 7;
    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 56;

    localparam logic KIND_MESH    = 1'b0;
    localparam logic KIND_TEXTURE = 1'b1;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_RELEASE = 3'd1,
        OP_COLLECT = 3'd2,
        OP_LOOKUP  = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_FOUND   = 2'd1,
        ST_CREATE_FAIL = 2'd2,
        ST_FULL        = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } fsm_t;

    typedef enum logic [1:0] {
        MATCH_FREE,
        MATCH_ID,
        MATCH_FENCE
    } match_mode_t;

    typedef struct packed {
        logic                kind;
        logic [ID_W-1:0]     id;
        logic [FENCE_W-1:0]  fence;
    } slot_rd_t;

    typedef struct packed {
        logic                meta_we;
        logic                fence_we;
        logic [IDX_W-1:0]    addr;
        logic                kind;
        logic [ID_W-1:0]     id;
        logic [FENCE_W-1:0]  fence;
    } slot_wr_t;

    // Id counters skip the null id when they wrap.
    function automatic logic [ID_W-1:0] bump_id(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] n;
        begin
            n = id + ID_W'(1);
            bump_id = (n == '0) ? ID_W'(1) : n;
        end
    endfunction

endpackage

### rtl/fdrt_slot_mem.sv
module fdrt_slot_mem (
    input  logic                    clk,
    input  fdrt_pkg::slot_wr_t      wr,
    input  logic                    rd_en,
    input  logic [fdrt_pkg::IDX_W-1:0] rd_addr,
    output fdrt_pkg::slot_rd_t      rd
);

    logic [fdrt_pkg::ID_W:0]      meta_mem  [fdrt_pkg::CAPACITY];
    logic [fdrt_pkg::FENCE_W-1:0] fence_mem [fdrt_pkg::CAPACITY];

    logic [fdrt_pkg::ID_W:0]      rd_meta_reg;
    logic [fdrt_pkg::FENCE_W-1:0] rd_fence_reg;

    always_ff @(posedge clk)
    begin
        if (wr.meta_we)
        begin
            meta_mem[wr.addr] <= {wr.kind, wr.id};
        end
        if (wr.fence_we)
        begin
            fence_mem[wr.addr] <= wr.fence;
        end
        if (rd_en)
        begin
            rd_meta_reg  <= meta_mem[rd_addr];
            rd_fence_reg <= fence_mem[rd_addr];
        end
    end

    assign rd.kind  = rd_meta_reg[fdrt_pkg::ID_W];
    assign rd.id    = rd_meta_reg[fdrt_pkg::ID_W-1:0];
    assign rd.fence = rd_fence_reg;

endmodule

### rtl/fdrt_match.sv
module fdrt_match (
    input  fdrt_pkg::match_mode_t       mode,
    input  logic                        slot_valid,
    input  logic                        slot_retired,
    input  fdrt_pkg::slot_rd_t          rd,
    input  logic                        key_kind,
    input  logic [fdrt_pkg::ID_W-1:0]   key_id,
    input  logic [fdrt_pkg::FENCE_W-1:0] key_fence,
    output logic                        hit
);

    always_comb
    begin
        case (mode)
            fdrt_pkg::MATCH_FREE:
                hit = !slot_valid;
            fdrt_pkg::MATCH_ID:
                hit = slot_valid && (rd.kind == key_kind) && (rd.id == key_id);
            fdrt_pkg::MATCH_FENCE:
                hit = slot_valid && slot_retired && (rd.fence <= key_fence);
            default:
                hit = 1'b0;
        endcase
    end

endmodule

### rtl/fenced_deferred_release_table_top.sv
// Resource table with fenced, deferred release.
// Input channel s_*: one beat is one command (create, release, collect, lookup,
// clear); s_tuser carries the resource kind. Output channel m_*: one result
// beat for every command, in order, with the status, the new handle, the hit
// flag and the resident and retired counts after the command.
// Create, release, lookup and collect sweep the slot table one slot per cycle
// through a single compare unit fed by the slot memory read port. A sweep
// for a free slot or an id stops at the first hit; collect always visits every
// slot. Clear, null-handle release and lookup, and unused opcodes skip the
// sweep and go straight to the result beat. One command is worked on at a
// time and s_tready is high only while the sequencer is idle.
// The result register lets the next command be accepted while a result beat
// is still waiting; a stalled m_tready holds that beat and holds the sequencer
// at the end of the following command.
// Reset empties the table at once (valid and retired flags are flip-flops)
// and sets both id counters to 1; no clearing pass is needed.
module fenced_deferred_release_table_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // opcode[2:0], handle_id[34:3], create_ok[35], fence_value[99:36], zero pad
    input  logic [fdrt_pkg::IN_DATA_W-1:0]    s_tdata,
    // kind
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], handle_out[33:2], found[34], resident_meshes[41:35],
    // resident_textures[48:42], retired_count[55:49]
    output logic [fdrt_pkg::OUT_DATA_W-1:0]   m_tdata
);

    `include "fenced_deferred_release_table_top_assert.svh"

    localparam int CAP   = fdrt_pkg::CAPACITY;
    localparam int IDX_W = fdrt_pkg::IDX_W;
    localparam int CNT_W = fdrt_pkg::CNT_W;
    localparam int ID_W  = fdrt_pkg::ID_W;
    localparam int FW    = fdrt_pkg::FENCE_W;
    localparam int COW   = fdrt_pkg::COUNT_OUT_W;

    fdrt_pkg::fsm_t state_reg, state_next;

    logic [2:0]       op_reg, op_next;
    logic             kind_reg, kind_next;
    logic [ID_W-1:0]  hid_reg, hid_next;
    logic             ok_reg, ok_next;
    logic [FW-1:0]    fence_reg, fence_next;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             issue_end_reg, issue_end_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;

    logic [CAP-1:0]   valid_reg, valid_next;
    logic [CAP-1:0]   retired_reg, retired_next;
    logic [CNT_W-1:0] nm_reg, nm_next;
    logic [CNT_W-1:0] nt_reg, nt_next;
    logic [CNT_W-1:0] nr_reg, nr_next;
    logic [ID_W-1:0]  mesh_id_reg, mesh_id_next;
    logic [ID_W-1:0]  tex_id_reg, tex_id_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [1:0]                    status_reg, status_next;
    logic [fdrt_pkg::HANDLE_W-1:0] hout_reg, hout_next;
    logic                          found_reg, found_next;
    logic [COW-1:0]                om_reg, om_next;
    logic [COW-1:0]                ot_reg, ot_next;
    logic [COW-1:0]                or_reg, or_next;

    fdrt_pkg::slot_wr_t    mem_wr;
    fdrt_pkg::slot_rd_t    mem_rd;
    logic                  rd_en;
    fdrt_pkg::match_mode_t mode;
    logic                  match_hit;

    fdrt_slot_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd      (mem_rd)
    );

    fdrt_match u_match (
        .mode         (mode),
        .slot_valid   (valid_reg[rd_idx_reg]),
        .slot_retired (retired_reg[rd_idx_reg]),
        .rd           (mem_rd),
        .key_kind     (kind_reg),
        .key_id       (hid_reg),
        .key_fence    (fence_reg),
        .hit          (match_hit)
    );

    always_comb
    begin
        case (op_reg)
            fdrt_pkg::OP_CREATE:  mode = fdrt_pkg::MATCH_FREE;
            fdrt_pkg::OP_COLLECT: mode = fdrt_pkg::MATCH_FENCE;
            default:              mode = fdrt_pkg::MATCH_ID;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fdrt_pkg::S_IDLE;
            issue_end_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            valid_reg     <= '0;
            retired_reg   <= '0;
            nm_reg        <= '0;
            nt_reg        <= '0;
            nr_reg        <= '0;
            mesh_id_reg   <= ID_W'(1);
            tex_id_reg    <= ID_W'(1);
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_end_reg <= issue_end_next;
            rd_vld_reg    <= rd_vld_next;
            hit_reg       <= hit_next;
            valid_reg     <= valid_next;
            retired_reg   <= retired_next;
            nm_reg        <= nm_next;
            nt_reg        <= nt_next;
            nr_reg        <= nr_next;
            mesh_id_reg   <= mesh_id_next;
            tex_id_reg    <= tex_id_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        kind_reg    <= kind_next;
        hid_reg     <= hid_next;
        ok_reg      <= ok_next;
        fence_reg   <= fence_next;
        idx_reg     <= idx_next;
        rd_idx_reg  <= rd_idx_next;
        hit_idx_reg <= hit_idx_next;
        status_reg  <= status_next;
        hout_reg    <= hout_next;
        found_reg   <= found_next;
        om_reg      <= om_next;
        ot_reg      <= ot_next;
        or_reg      <= or_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        kind_next      = kind_reg;
        hid_next       = hid_reg;
        ok_next        = ok_reg;
        fence_next     = fence_reg;
        idx_next       = idx_reg;
        issue_end_next = issue_end_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        valid_next     = valid_reg;
        retired_next   = retired_reg;
        nm_next        = nm_reg;
        nt_next        = nt_reg;
        nr_next        = nr_reg;
        mesh_id_next   = mesh_id_reg;
        tex_id_next    = tex_id_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        status_next    = status_reg;
        hout_next      = hout_reg;
        found_next     = found_reg;
        om_next        = om_reg;
        ot_next        = ot_reg;
        or_next        = or_reg;
        s_tready       = 1'b0;
        rd_en          = 1'b0;
        mem_wr         = '0;
        mem_wr.addr    = hit_idx_reg;
        mem_wr.kind    = kind_reg;
        mem_wr.fence   = fence_reg;

        case (state_reg)
            fdrt_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next        = s_tdata[2:0];
                    kind_next      = s_tuser;
                    hid_next       = ID_W'(s_tdata[34:3]);
                    ok_next        = s_tdata[35];
                    fence_next     = s_tdata[99:36];
                    idx_next       = '0;
                    issue_end_next = 1'b0;
                    hit_next       = 1'b0;
                    case (s_tdata[2:0])
                        fdrt_pkg::OP_CREATE,
                        fdrt_pkg::OP_COLLECT:
                            state_next = fdrt_pkg::S_SWEEP;
                        fdrt_pkg::OP_RELEASE,
                        fdrt_pkg::OP_LOOKUP:
                            state_next = (ID_W'(s_tdata[34:3]) == '0) ? fdrt_pkg::S_DONE
                                                                       : fdrt_pkg::S_SWEEP;
                        default:
                            state_next = fdrt_pkg::S_DONE;
                    endcase
                end
            end

            fdrt_pkg::S_SWEEP:
            begin
                // Issue one slot read per cycle; the compare sees it in the next cycle.
                if (!issue_end_reg)
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg;
                    idx_next    = idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_W'(CAP - 1))
                    begin
                        issue_end_next = 1'b1;
                    end
                end
                if (rd_vld_reg)
                begin
                    if (match_hit && op_reg == fdrt_pkg::OP_COLLECT)
                    begin
                        valid_next[rd_idx_reg]   = 1'b0;
                        retired_next[rd_idx_reg] = 1'b0;
                        nr_next = nr_reg - CNT_W'(1);
                        if (mem_rd.kind == fdrt_pkg::KIND_MESH)
                        begin
                            nm_next = nm_reg - CNT_W'(1);
                        end
                        else
                        begin
                            nt_next = nt_reg - CNT_W'(1);
                        end
                    end
                    if (match_hit && op_reg != fdrt_pkg::OP_COLLECT)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = rd_idx_reg;
                        rd_vld_next  = 1'b0;
                        state_next   = fdrt_pkg::S_DONE;
                    end
                    else if (rd_idx_reg == IDX_W'(CAP - 1))
                    begin
                        rd_vld_next = 1'b0;
                        state_next  = fdrt_pkg::S_DONE;
                    end
                end
            end

            fdrt_pkg::S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    status_next = fdrt_pkg::ST_OK;
                    hout_next   = '0;
                    found_next  = 1'b0;
                    case (op_reg)
                        fdrt_pkg::OP_CREATE:
                        begin
                            if (!hit_reg)
                            begin
                                status_next = fdrt_pkg::ST_FULL;
                            end
                            else if (kind_reg == fdrt_pkg::KIND_MESH)
                            begin
                                // A failed mesh create still consumes its id.
                                mesh_id_next = fdrt_pkg::bump_id(mesh_id_reg);
                                if (ok_reg)
                                begin
                                    mem_wr.meta_we            = 1'b1;
                                    mem_wr.id                 = mesh_id_reg;
                                    valid_next[hit_idx_reg]   = 1'b1;
                                    retired_next[hit_idx_reg] = 1'b0;
                                    nm_next   = nm_reg + CNT_W'(1);
                                    hout_next = fdrt_pkg::HANDLE_W'(mesh_id_reg);
                                end
                                else
                                begin
                                    status_next = fdrt_pkg::ST_CREATE_FAIL;
                                end
                            end
                            else if (ok_reg)
                            begin
                                tex_id_next               = fdrt_pkg::bump_id(tex_id_reg);
                                mem_wr.meta_we            = 1'b1;
                                mem_wr.id                 = tex_id_reg;
                                valid_next[hit_idx_reg]   = 1'b1;
                                retired_next[hit_idx_reg] = 1'b0;
                                nt_next   = nt_reg + CNT_W'(1);
                                hout_next = fdrt_pkg::HANDLE_W'(tex_id_reg);
                            end
                            else
                            begin
                                status_next = fdrt_pkg::ST_CREATE_FAIL;
                            end
                        end
                        fdrt_pkg::OP_RELEASE:
                        begin
                            if (hit_reg)
                            begin
                                mem_wr.fence_we = 1'b1;
                                found_next      = 1'b1;
                                if (!retired_reg[hit_idx_reg])
                                begin
                                    nr_next = nr_reg + CNT_W'(1);
                                end
                                retired_next[hit_idx_reg] = 1'b1;
                            end
                            else
                            begin
                                status_next = fdrt_pkg::ST_NOT_FOUND;
                            end
                        end
                        fdrt_pkg::OP_LOOKUP:
                        begin
                            if (hit_reg)
                            begin
                                found_next = 1'b1;
                            end
                            else
                            begin
                                status_next = fdrt_pkg::ST_NOT_FOUND;
                            end
                        end
                        fdrt_pkg::OP_CLEAR:
                        begin
                            valid_next   = '0;
                            retired_next = '0;
                            nm_next      = '0;
                            nt_next      = '0;
                            nr_next      = '0;
                        end
                        default:
                        begin
                            status_next = fdrt_pkg::ST_OK;
                        end
                    endcase
                    om_next       = COW'(nm_next);
                    ot_next       = COW'(nt_next);
                    or_next       = COW'(nr_next);
                    m_tvalid_next = 1'b1;
                    state_next    = fdrt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fdrt_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {or_reg, ot_reg, om_reg, found_reg, hout_reg, status_reg};

    `FDRT_ASSERT_ALWAYS(a_resident_count,
        (int'(nm_reg) + int'(nt_reg)) == $countones(valid_reg),
        "resident counters disagree with the slot valid flags")
    `FDRT_ASSERT_ALWAYS(a_retired_count, int'(nr_reg) == $countones(retired_reg),
        "retired counter disagrees with the retired flags")
    `FDRT_ASSERT_ALWAYS(a_retired_resident, (retired_reg & ~valid_reg) == '0,
        "a retired slot is not resident")
    `FDRT_ASSERT_NEXT(a_one_result, state_reg == fdrt_pkg::S_DONE && (!m_tvalid_reg || m_tready),
        m_tvalid_reg && state_reg == fdrt_pkg::S_IDLE,
        "finished command did not present its result beat")

endmodule
